// ----- rtl/rrss_pkg.sv -----
// Package for the round-robin slice scheduler: word types, codes and defaults.
// Used by every module of the block; depends on nothing.
package rrss_pkg;

  localparam int DefaultMaxTasks = 64;
  localparam logic [15:0] QuantumReset = 16'd4;

  localparam logic [1:0] CmdLoad   = 2'd0;
  localparam logic [1:0] CmdSlice  = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [2:0] StatSlice   = 3'd0;
  localparam logic [2:0] StatDone    = 3'd1;
  localparam logic [2:0] StatLoaded  = 3'd2;
  localparam logic [2:0] StatRefused = 3'd3;
  localparam logic [2:0] StatCleared = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] arrival;
    logic [15:0] burst;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  task_index;
    logic [31:0] start_time;
    logic [15:0] run_length;
    logic        task_finished;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;       // empty table, zero time
    logic scan_init;   // latch the command, set up the scan
    logic scan_step;   // look at one entry
    logic shift_step;  // move one entry up for an insertion
    logic load_write;  // write the new entry
    logic slice_apply; // update the picked entry and time
    logic idle_init;   // restart scan at the head for an idle pass
  } dp_cmd_t;

  typedef struct packed {
    logic scan_hit;    // current entry matches
    logic scan_last;   // current entry is the last one to look at
    logic shift_done;  // no more entries to move
    logic empty;       // nothing left to schedule
    logic full;        // table full
    logic mem_wait;    // read data not yet valid
  } dp_stat_t;

endpackage

// ----- rtl/rrss_datapath.sv -----
// Datapath of the round-robin slice scheduler: task table memory, counters,
// time and scan cursor. Depends on rrss_pkg; driven by rrss_ctrl.
module rrss_datapath #(
  parameter int MaxTasks = rrss_pkg::DefaultMaxTasks
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          quantum,
  input  rrss_pkg::in_word_t   in_word,
  input  rrss_pkg::dp_cmd_t    cmd,
  input  logic                 idle_pass,
  output rrss_pkg::dp_stat_t   stat,
  output rrss_pkg::out_word_t  res_load,
  output rrss_pkg::out_word_t  res_slice
);
  import rrss_pkg::*;

  localparam int Aw = $clog2(MaxTasks);
  localparam int Cw = $clog2(MaxTasks + 1);

  // one combined entry: arrival, remaining, order number
  typedef struct packed {
    logic [15:0] arr;
    logic [15:0] rem;
    logic [5:0]  ord;
  } entry_t;

  entry_t mem [MaxTasks];
  entry_t rd;
  logic [Aw-1:0] rd_addr, wr_addr;
  logic          wr_en;
  entry_t        wr_data;

  logic [Cw-1:0] task_count, unfinished_count;
  logic [31:0]   clock_now;
  logic [Aw-1:0] scan_cursor;
  logic [Aw-1:0] idx;      // entry being looked at
  logic [Cw-1:0] seen;     // entries looked at so far
  logic          rd_valid;
  logic [15:0]   arr_l, bur_l;
  logic [Aw-1:0] pick;
  entry_t        pick_e;
  logic [15:0]   mem_arr_below;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd <= mem[rd_addr];
  end

  logic [Cw-1:0] last_seen;
  assign last_seen = task_count - Cw'(1);
  logic [Aw-1:0] idx_inc;
  assign idx_inc = ({1'b0, idx} + (Aw+1)'(1) >= (Aw+1)'(task_count)) ? '0 : idx + Aw'(1);

  // Scan address advances on a step; shift reads the entry below the write slot.
  always_comb begin
    rd_addr = idx;
    if (cmd.scan_step && rd_valid) rd_addr = idx_inc;
    if (cmd.shift_step) rd_addr = idx - Aw'(1);
  end

  assign mem_arr_below = rd.arr;

  logic eligible;
  assign eligible = (rd.rem != 16'd0) && ({16'd0, rd.arr} <= clock_now);
  assign stat.scan_hit   = rd_valid && (idle_pass ? (rd.rem != 16'd0) : eligible);
  assign stat.scan_last  = (seen == last_seen);
  assign stat.shift_done = (idx == '0) || (arr_l >= mem_arr_below);
  assign stat.empty      = (unfinished_count == '0) || (task_count == '0);
  assign stat.full       = (task_count == Cw'(MaxTasks));
  assign stat.mem_wait   = !rd_valid;

  logic [15:0] q, run;
  logic [31:0] slice_start;
  assign q   = (quantum == 16'd0) ? 16'd1 : quantum;
  assign run = (pick_e.rem < q) ? pick_e.rem : q;
  assign slice_start = idle_pass ? {16'd0, pick_e.arr} : clock_now;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx;
    wr_data = rd;
    if (cmd.shift_step && rd_valid) begin
      wr_en = 1'b1;
    end else if (cmd.load_write) begin
      wr_en = 1'b1;
      wr_data = '{arr: arr_l, rem: bur_l, ord: 6'(task_count)};
    end else if (cmd.slice_apply) begin
      wr_en = 1'b1;
      wr_addr = pick;
      wr_data = '{arr: pick_e.arr, rem: pick_e.rem - run, ord: pick_e.ord};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      task_count <= '0;
      unfinished_count <= '0;
      clock_now <= '0;
      scan_cursor <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.scan_init) begin
        arr_l <= in_word.arrival;
        bur_l <= in_word.burst;
        seen <= '0;
        if (in_word.cmd == CmdLoad) begin
          idx <= Aw'(task_count);
        end else begin
          idx <= ({1'b0, scan_cursor} < (Aw+1)'(task_count)) ? scan_cursor : '0;
        end
        rd_valid <= 1'b0;
      end else if (cmd.idle_init) begin
        idx <= '0;
        seen <= '0;
        rd_valid <= 1'b0;
      end else if (cmd.shift_step) begin
        if (rd_valid) idx <= idx - Aw'(1);
        rd_valid <= !rd_valid ? 1'b1 : 1'b0;
      end else if (cmd.scan_step) begin
        if (rd_valid) begin
          if (stat.scan_hit) begin
            pick <= idx;
            pick_e <= rd;
          end else begin
            idx <= idx_inc;
            seen <= seen + Cw'(1);
          end
        end
        rd_valid <= !rd_valid ? 1'b1 : !stat.scan_hit;
      end else begin
        rd_valid <= 1'b0;
      end
      if (cmd.load_write) begin
        task_count <= task_count + Cw'(1);
        unfinished_count <= unfinished_count + Cw'(1);
      end
      if (cmd.slice_apply) begin
        clock_now <= slice_start + {16'd0, run};
        if (pick_e.rem == run) unfinished_count <= unfinished_count - Cw'(1);
        scan_cursor <= ({1'b0, pick} + (Aw+1)'(1) >= (Aw+1)'(task_count)) ? '0 : pick + Aw'(1);
      end
    end
  end

  assign res_load  = '{status: StatLoaded, task_index: 6'(task_count),
                       start_time: '0, run_length: '0, task_finished: 1'b0};
  assign res_slice = '{status: StatSlice, task_index: pick_e.ord, start_time: slice_start,
                       run_length: run, task_finished: (pick_e.rem == run)};

  assert property (@(posedge clk) disable iff (rst) cmd.load_write |-> !stat.full)
    else $error("load written into a full table");
  assert property (@(posedge clk) disable iff (rst)
                   unfinished_count <= task_count)
    else $error("more unfinished tasks than tasks");
  assert property (@(posedge clk) disable iff (rst)
                   cmd.slice_apply |-> pick_e.rem != 16'd0)
    else $error("slice picked a finished task");
endmodule

// ----- rtl/rrss_ctrl.sv -----
// Controller of the round-robin slice scheduler: sequences loads, scans and
// result delivery. Depends on rrss_pkg; drives rrss_datapath.
module rrss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrss_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output rrss_pkg::out_word_t out_word,
  output rrss_pkg::dp_cmd_t   cmd,
  output logic                idle_pass,
  input  rrss_pkg::dp_stat_t  stat,
  input  rrss_pkg::out_word_t res_load,
  input  rrss_pkg::out_word_t res_slice
);
  import rrss_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_SHIFT = 6'b000100,
    S_WRITE = 6'b001000,
    S_SCAN  = 6'b010000,
    S_APPLY = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [1:0] op;
  logic       burst_zero;
  logic       out_free, refuse, nothing_left, dec_result, dec_load, out_load;
  logic [2:0] dec_status;

  // The output register holds a word until taken; the next word is accepted
  // meanwhile and waits only at the step that writes its own result.
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign refuse       = (op == CmdLoad) && (burst_zero || stat.full);
  assign nothing_left = (op == CmdSlice) && stat.empty;
  assign dec_result   = refuse || nothing_left || (op == CmdClear);
  assign dec_status   = (op == CmdClear) ? StatCleared : nothing_left ? StatDone : StatRefused;
  assign dec_load     = (state == S_DEC) && dec_result && out_free;
  assign out_load     = dec_load || cmd.load_write || cmd.slice_apply;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.scan_init = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (dec_result) begin
          if (out_free) begin
            cmd.clear = (op == CmdClear);
            state_next = S_IDLE;
          end
        end else if (op == CmdLoad) begin
          state_next = S_SHIFT;
        end else if (op == CmdSlice) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (!stat.mem_wait && stat.shift_done) begin
          cmd.shift_step = 1'b0;
          state_next = S_WRITE;
        end
      end
      S_WRITE: if (out_free) begin
        cmd.load_write = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) state_next = S_APPLY;
        else if (!stat.mem_wait && stat.scan_last) begin
          cmd.scan_step = 1'b0;
          cmd.idle_init = 1'b1;
        end
      end
      S_APPLY: if (out_free) begin
        cmd.slice_apply = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      idle_pass <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_load || (out_valid && !out_ready);
      if (state == S_IDLE && in_valid) begin
        op <= in_word.cmd;
        burst_zero <= (in_word.burst == 16'd0);
        idle_pass <= 1'b0;
      end
      if (cmd.idle_init) idle_pass <= 1'b1;
      if (dec_load) out_word <= '{status: dec_status, default: '0};
      if (cmd.load_write) out_word <= res_load;
      if (cmd.slice_apply) out_word <= res_slice;
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !out_ready |=> $stable(out_word))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> state == S_IDLE)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
endmodule

// ----- rtl/round_robin_slice_scheduler.sv -----
// Top level of the round-robin slice scheduler: quantum register, controller
// and datapath. Depends on rrss_pkg, rrss_ctrl and rrss_datapath.
//
// Usage: input words (cmd, arrival, burst) enter on in_valid/in_ready, result
// words leave on out_valid/out_ready, one result per command (cmd 3 gives
// none). quantum_we writes the 16-bit quantum; write it only while idle.
// A load walks down from the table end moving entries up until it finds its
// slot. A slice scans from the cursor, one entry per cycle after a table
// read; when nothing has arrived the whole table is scanned and then scanned
// again from the head for the idle pass. Clear, refused loads, slices with
// nothing left and cmd 3 are settled at the decode step. Each result appears
// the cycle after its last step. The output register holds a result until
// taken; the next word is accepted meanwhile and the block stalls only when
// it has a further result to write. Reset empties the table, zeroes time and
// cursor and sets quantum to 4; no table clearing pass.
module round_robin_slice_scheduler #(
  parameter int MaxTasks = rrss_pkg::DefaultMaxTasks
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrss_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rrss_pkg::out_word_t out_data,
  input  logic                quantum_we,
  input  logic [15:0]         quantum_wdata
);
  import rrss_pkg::*;

  logic [15:0] quantum;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  out_word_t   res_load, res_slice;
  logic        idle_pass;

  always_ff @(posedge clk) begin
    if (rst) quantum <= QuantumReset;
    else if (quantum_we) quantum <= quantum_wdata;
  end

  rrss_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready,
    .in_word(in_data), .out_valid, .out_ready, .out_word(out_data),
    .cmd, .idle_pass, .stat, .res_load, .res_slice
  );

  rrss_datapath #(.MaxTasks(MaxTasks)) u_dp (
    .clk, .rst, .quantum, .in_word(in_data), .cmd, .idle_pass,
    .stat, .res_load, .res_slice
  );
endmodule

// ----- bench/round_robin_slice_scheduler_test.sv -----
// Testbench for the round-robin slice scheduler: random and directed command
// words checked against a behavioral scheduler. Depends on rrss_pkg and the RTL.
module round_robin_slice_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rrss_pkg::*;

  localparam int MaxTasks = DefaultMaxTasks;
  localparam int CycleLimit = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic quantum_we = 1'b0;
  logic [15:0] quantum_wdata = '0;

  round_robin_slice_scheduler dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .quantum_we(quantum_we), .quantum_wdata(quantum_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Scheduler state mirror.
  logic [15:0] arr_tab [MaxTasks];
  logic [15:0] rem_tab [MaxTasks];
  logic [5:0]  ord_tab [MaxTasks];
  int unsigned n_tasks, n_open, cursor;
  logic [31:0] now;
  logic [15:0] quantum;

  in_word_t  pending_words[$];
  out_word_t expected_results[$];
  int errors = 0;
  int accepted = 0;
  int results_seen = 0;
  int slices_seen = 0;
  bit quiet = 1'b0;        // no idling on either side
  bit long_hold = 1'b0;    // receiver holds off
  bit all_sent = 1'b0;
  longint cycles = 0;

  function automatic out_word_t schedule_word(in_word_t w);
    out_word_t r;
    int unsigned pos, first, i, pick;
    logic [15:0] q, run;
    bit found;
    r = '0;
    case (w.cmd)
      CmdLoad: begin
        if (w.burst == 0 || n_tasks >= MaxTasks) begin
          r.status = StatRefused;
        end else begin
          pos = 0;
          while (pos < n_tasks && arr_tab[pos] <= w.arrival) pos++;
          for (int k = n_tasks; k > pos; k--) begin
            arr_tab[k] = arr_tab[k-1];
            rem_tab[k] = rem_tab[k-1];
            ord_tab[k] = ord_tab[k-1];
          end
          arr_tab[pos] = w.arrival;
          rem_tab[pos] = w.burst;
          ord_tab[pos] = 6'(n_tasks);
          r.status = StatLoaded;
          r.task_index = 6'(n_tasks);
          n_tasks++;
          n_open++;
        end
      end
      CmdSlice: begin
        if (n_open == 0 || n_tasks == 0) begin
          r.status = StatDone;
        end else begin
          found = 1'b0;
          pick = 0;
          first = (cursor < n_tasks) ? cursor : 0;
          for (int n = 0; n < n_tasks && !found; n++) begin
            i = (first + n) % n_tasks;
            if (rem_tab[i] != 0 && {16'd0, arr_tab[i]} <= now) begin
              pick = i;
              found = 1'b1;
            end
          end
          if (!found) begin
            // Nothing has arrived: jump to the earliest pending arrival.
            for (i = 0; i < n_tasks && !found; i++) begin
              if (rem_tab[i] != 0) begin
                pick = i;
                found = 1'b1;
              end
            end
            now = {16'd0, arr_tab[pick]};
          end
          q = (quantum == 0) ? 16'd1 : quantum;
          run = (rem_tab[pick] < q) ? rem_tab[pick] : q;
          rem_tab[pick] = rem_tab[pick] - run;
          r.status = StatSlice;
          r.task_index = ord_tab[pick];
          r.start_time = now;
          r.run_length = run;
          r.task_finished = (rem_tab[pick] == 0);
          now = now + {16'd0, run};
          if (rem_tab[pick] == 0) n_open--;
          cursor = (pick + 1 >= n_tasks) ? 0 : pick + 1;
        end
      end
      CmdClear: begin
        n_tasks = 0;
        n_open = 0;
        now = '0;
        cursor = 0;
        r.status = StatCleared;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Driver: offers queued words, with idle bursts.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (pending_words[0].cmd != CmdUnused)
          expected_results.push_back(schedule_word(pending_words[0]));
        void'(pending_words.pop_front());
        accepted++;
      end
      if (in_valid && !in_ready) begin
        // hold the word
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > (in_valid && in_ready ? 0 : 0) &&
                   pending_words.size() != 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(1, 10);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_words[0];
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall.
  int recv_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result word %p", out_data);
          errors++;
        end else begin
          out_word_t e;
          e = expected_results.pop_front();
          if (e.status == StatSlice) slices_seen++;
          if (out_data.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_data.status); errors++;
          end
          if (out_data.task_index !== e.task_index) begin
            $error("task_index: expected %0d, got %0d", e.task_index, out_data.task_index);
            errors++;
          end
          if (out_data.start_time !== e.start_time) begin
            $error("start_time: expected %0d, got %0d", e.start_time, out_data.start_time);
            errors++;
          end
          if (out_data.run_length !== e.run_length) begin
            $error("run_length: expected %0d, got %0d", e.run_length, out_data.run_length);
            errors++;
          end
          if (out_data.task_finished !== e.task_finished) begin
            $error("task_finished: expected %0d, got %0d", e.task_finished,
                   out_data.task_finished);
            errors++;
          end
        end
      end
      if (long_hold) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(1, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("round_robin_slice_scheduler test failed");
      $finish;
    end
  end

  function automatic in_word_t make_word(logic [1:0] c, logic [15:0] a, logic [15:0] b);
    in_word_t w;
    w.cmd = c;
    w.arrival = a;
    w.burst = b;
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    // A trailing cmd 3 word gives no result; let the block settle.
    repeat (4 * MaxTasks + 10) @(posedge clk);
  endtask

  task automatic write_quantum(logic [15:0] v);
    quantum_we <= 1'b1;
    quantum_wdata <= v;
    @(posedge clk);
    quantum_we <= 1'b0;
    quantum = v;
  endtask

  // One workload: a few loads, then mostly slices, with some noise.
  task automatic queue_episode(int loads, bit small_times);
    int r;
    pending_words.push_back(make_word(CmdClear, 16'($urandom), 16'($urandom)));
    for (int k = 0; k < loads; k++) begin
      r = $urandom_range(0, 19);
      if (r == 0)
        pending_words.push_back(make_word(CmdLoad, 16'($urandom), 16'd0));
      else if (small_times)
        pending_words.push_back(make_word(CmdLoad, 16'($urandom_range(0, 40)),
                                          16'($urandom_range(1, 12))));
      else
        pending_words.push_back(make_word(CmdLoad, 16'($urandom), 16'($urandom_range(1, 65535))));
    end
    for (int k = 0; k < loads + 8; k++) begin
      r = $urandom_range(0, 29);
      if (r == 0)
        pending_words.push_back(make_word(CmdUnused, 16'($urandom), 16'($urandom)));
      else if (r == 1)
        pending_words.push_back(make_word(CmdLoad, 16'($urandom_range(0, 60)),
                                          16'($urandom_range(1, 8))));
      else
        pending_words.push_back(make_word(CmdSlice, 16'($urandom), 16'($urandom)));
    end
  endtask

  initial begin
    quantum = QuantumReset;
    n_tasks = 0; n_open = 0; now = '0; cursor = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset quantum, extremes, ties, idle jump, refusals, unused cmd.
    pending_words.push_back(make_word(CmdSlice, 16'hFFFF, 16'hFFFF));
    pending_words.push_back(make_word(CmdLoad, 16'd0, 16'd0));
    pending_words.push_back(make_word(CmdLoad, 16'd100, 16'd5));
    pending_words.push_back(make_word(CmdLoad, 16'd100, 16'd3));
    pending_words.push_back(make_word(CmdLoad, 16'd0, 16'd1));
    pending_words.push_back(make_word(CmdLoad, 16'hFFFF, 16'hFFFF));
    pending_words.push_back(make_word(CmdUnused, 16'hFFFF, 16'hFFFF));
    repeat (8) pending_words.push_back(make_word(CmdSlice, 16'd0, 16'd0));
    pending_words.push_back(make_word(CmdLoad, 16'd2, 16'd4));
    repeat (3) pending_words.push_back(make_word(CmdSlice, 16'd0, 16'd0));
    pending_words.push_back(make_word(CmdClear, 16'd0, 16'd0));
    pending_words.push_back(make_word(CmdSlice, 16'd0, 16'd0));
    wait_drained();

    // Full table, refusal, then quantum extremes.
    write_quantum(16'd0);
    pending_words.push_back(make_word(CmdClear, 16'd0, 16'd0));
    for (int k = 0; k < MaxTasks + 2; k++)
      pending_words.push_back(make_word(CmdLoad, 16'($urandom_range(0, 3)), 16'd2));
    repeat (12) pending_words.push_back(make_word(CmdSlice, 16'd0, 16'd0));
    wait_drained();
    write_quantum(16'hFFFF);
    queue_episode(10, 1'b0);
    wait_drained();

    // Receiver holds off while the sender keeps offering words.
    write_quantum(16'd3);
    long_hold = 1'b1;
    queue_episode(12, 1'b1);
    repeat (400) @(posedge clk);
    long_hold = 1'b0;
    wait_drained();

    // Random phases over several quantum settings.
    for (int ph = 0; ph < 35; ph++) begin
      write_quantum((ph % 5 == 0) ? 16'd1 : 16'($urandom_range(1, 20)));
      quiet = (ph >= 30);
      queue_episode($urandom_range(3, 22), ($urandom_range(0, 3) != 0));
      wait_drained();
    end
    all_sent = 1'b1;

    $display("Ran %0d command words, %0d results, %0d slices checked.",
             accepted, results_seen, slices_seen);
    if (errors == 0 && expected_results.size() == 0)
      $display("round_robin_slice_scheduler test passed");
    else
      $display("round_robin_slice_scheduler test failed");
    $finish;
  end
endmodule
